/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the design files, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed in %m")
// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed in %m")
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* design/tbfag_pkg.sv */
// ---------------------------------------------------------------------------
// tbfag_pkg
// Shared types and codes of the text background fetch address generator.
// ---------------------------------------------------------------------------
package tbfag_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_H_SCROLL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_V_SCROLL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_SIZE_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EIGHT_BIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_BASE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_BASE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MOSAIC_EN     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MOSAIC_HEIGHT = 3'd7;

    localparam logic ACT_START_LINE = 1'b0;
    localparam logic ACT_MAP_ENTRY  = 1'b1;

    localparam logic KIND_FETCH = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef struct packed {
        logic take_item;   // latch input fields, arm divider, seed pixel counter
        logic div_step;    // one remainder bit of the mosaic floor
        logic row_load;    // commit wrapped map row, column back to zero
        logic out_fetch;   // load output register with a map fetch
        logic out_pix;     // load output register with a pixel, advance column
    } cmd_t;

    typedef struct packed {
        logic mosaic_on;
        logic div_last;
        logic col_last;    // current pixel is the last screen column
        logic tile_last;   // current pixel is the right edge of the tile
    } status_t;

endpackage

/* design/tbfag_ctrl.sv */
// ---------------------------------------------------------------------------
// tbfag_ctrl
// Sequencer: input handshake, line state, output register valid.
// ---------------------------------------------------------------------------
module tbfag_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               in_action,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  tbfag_pkg::status_t status,
    output tbfag_pkg::cmd_t    cmd
);
    import tbfag_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_ROW   = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_PIX   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       busy_reg, busy_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        busy_next  = busy_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.take_item = 1'b1;
                    if (in_action == ACT_START_LINE) begin
                        state_next = status.mosaic_on ? S_DIV : S_ROW;
                    end else if (busy_reg) begin
                        state_next = S_PIX;
                    end
                    // map entry with no line open is dropped
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = S_ROW;
                end
            end
            S_ROW: begin
                cmd.row_load = 1'b1;
                busy_next    = 1'b1;
                state_next   = S_FETCH;
            end
            S_FETCH: begin
                if (out_free) begin
                    cmd.out_fetch = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_PIX: begin
                if (out_free) begin
                    cmd.out_pix = 1'b1;
                    if (status.col_last) begin
                        busy_next  = 1'b0;
                        state_next = S_IDLE;
                    end else if (status.tile_last) begin
                        state_next = S_FETCH;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_fetch || cmd.out_pix) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* design/tbfag_datapath.sv */
// ---------------------------------------------------------------------------
// tbfag_datapath
// Config registers, mosaic divider, line position and address arithmetic.
// ---------------------------------------------------------------------------
module tbfag_datapath #(
    parameter int SCREEN_COLUMNS     = 240,
    parameter int SCREEN_BLOCK_BYTES = 2048
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [tbfag_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbfag_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [7:0]                         in_scanline,
    input  logic [15:0]                        in_entry,
    input  tbfag_pkg::cmd_t                    cmd,
    output tbfag_pkg::status_t                 status,
    output logic                               out_kind,
    output logic [31:0]                        out_addr,
    output logic                               out_odd,
    output logic [3:0]                         out_pal,
    output logic [7:0]                         out_x,
    output logic                               out_last
);
    import tbfag_pkg::*;

    // configuration
    logic [8:0]  h_scroll_reg, v_scroll_reg;
    logic [1:0]  map_size_reg;
    logic        eight_bit_reg;
    logic [31:0] map_base_reg, tile_base_reg;
    logic        mosaic_en_reg;
    logic [4:0]  mosaic_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_scroll_reg  <= '0;
            v_scroll_reg  <= '0;
            map_size_reg  <= '0;
            eight_bit_reg <= 1'b0;
            map_base_reg  <= '0;
            tile_base_reg <= '0;
            mosaic_en_reg <= 1'b0;
            mosaic_h_reg  <= 5'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_H_SCROLL:      h_scroll_reg  <= cfg_wdata[8:0];
                REG_V_SCROLL:      v_scroll_reg  <= cfg_wdata[8:0];
                REG_MAP_SIZE_MODE: map_size_reg  <= cfg_wdata[1:0];
                REG_EIGHT_BIT:     eight_bit_reg <= cfg_wdata[0];
                REG_MAP_BASE:      map_base_reg  <= cfg_wdata;
                REG_TILE_BASE:     tile_base_reg <= cfg_wdata;
                REG_MOSAIC_EN:     mosaic_en_reg <= cfg_wdata[0];
                REG_MOSAIC_HEIGHT: mosaic_h_reg  <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // restoring remainder of scanline / mosaic height, one bit per cycle
    logic [7:0] y_reg, dvd_reg;
    logic [5:0] rem_reg;
    logic [2:0] div_cnt_reg;
    logic [4:0] div_h;
    logic [5:0] rem_shift, rem_sub;

    assign div_h     = (mosaic_h_reg == 5'd0) ? 5'd1 : mosaic_h_reg;
    assign rem_shift = {rem_reg[4:0], dvd_reg[7]};
    assign rem_sub   = (rem_shift >= {1'b0, div_h}) ? rem_shift - {1'b0, div_h} : rem_shift;

    // line position and latched map entry
    logic [8:0] map_row_y_reg;
    logic [7:0] column_reg;
    logic [2:0] p_reg;
    logic [9:0] tile_reg;
    logic       hf_reg, vf_reg;
    logic [3:0] pal_reg;

    logic [7:0] y_floor;
    logic [9:0] row_sum;
    logic [8:0] row_wrapped;

    assign y_floor     = mosaic_en_reg ? y_reg - {2'b00, rem_reg} : y_reg;
    assign row_sum     = {2'b00, y_floor} + {1'b0, v_scroll_reg};
    assign row_wrapped = map_size_reg[1] ? row_sum[8:0] : {1'b0, row_sum[7:0]};

    // map fetch address
    logic [9:0]  bx_sum;
    logic [8:0]  bg_x;
    logic [5:0]  tx, ty;
    logic [1:0]  blk;
    logic [31:0] blk_off, fetch_addr;

    assign bx_sum = {2'b00, column_reg} + {1'b0, h_scroll_reg};
    assign bg_x   = map_size_reg[0] ? bx_sum[8:0] : {1'b0, bx_sum[7:0]};
    assign tx     = bg_x[8:3];
    assign ty     = map_row_y_reg[8:3];

    always_comb begin
        case (map_size_reg)
            2'd1:    blk = {1'b0, tx[5]};
            2'd2:    blk = {1'b0, ty[5]};
            2'd3:    blk = {ty[5], tx[5]};
            default: blk = 2'd0;
        endcase
    end

    assign blk_off    = 32'(blk) * 32'(SCREEN_BLOCK_BYTES);
    assign fetch_addr = map_base_reg + blk_off + {21'b0, ty[4:0], tx[4:0], 1'b0};

    // pixel byte address
    logic [2:0]  px, py;
    logic [15:0] tile_off;
    logic [5:0]  row_off;
    logic [2:0]  pix_off;
    logic [31:0] pix_addr;
    logic [8:0]  col_inc;

    assign px       = p_reg ^ {3{hf_reg}};
    assign py       = vf_reg ? ~map_row_y_reg[2:0] : map_row_y_reg[2:0];
    assign tile_off = eight_bit_reg ? {tile_reg, 6'b0} : {1'b0, tile_reg, 5'b0};
    assign row_off  = eight_bit_reg ? {py, 3'b0} : {1'b0, py, 2'b0};
    assign pix_off  = eight_bit_reg ? px : {1'b0, px[2:1]};
    assign pix_addr = tile_base_reg + {16'b0, tile_off} + {26'b0, row_off}
                    + {29'b0, pix_off};
    assign col_inc  = {1'b0, column_reg} + 9'd1;

    assign status.mosaic_on = mosaic_en_reg;
    assign status.div_last  = (div_cnt_reg == 3'd7);
    assign status.col_last  = (col_inc == 9'(SCREEN_COLUMNS));
    assign status.tile_last = (p_reg == 3'd7);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_row_y_reg <= '0;
            column_reg    <= '0;
        end else if (cmd.row_load) begin
            map_row_y_reg <= row_wrapped;
            column_reg    <= '0;
        end else if (cmd.out_pix) begin
            column_reg    <= col_inc[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            y_reg       <= in_scanline;
            dvd_reg     <= in_scanline;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
            tile_reg    <= in_entry[9:0];
            hf_reg      <= in_entry[10];
            vf_reg      <= in_entry[11];
            pal_reg     <= in_entry[15:12];
            p_reg       <= column_reg[2:0] + h_scroll_reg[2:0];
        end else begin
            if (cmd.div_step) begin
                rem_reg     <= rem_sub;
                dvd_reg     <= {dvd_reg[6:0], 1'b0};
                div_cnt_reg <= div_cnt_reg + 3'd1;
            end
            if (cmd.out_pix) begin
                p_reg <= p_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_fetch) begin
            out_kind <= KIND_FETCH;
            out_addr <= fetch_addr;
            out_odd  <= 1'b0;
            out_pal  <= 4'd0;
            out_x    <= column_reg;
            out_last <= 1'b1;
        end else if (cmd.out_pix) begin
            out_kind <= KIND_PIXEL;
            out_addr <= pix_addr;
            out_odd  <= px[0];
            out_pal  <= eight_bit_reg ? 4'd0 : pal_reg;
            out_x    <= column_reg;
            out_last <= status.col_last;
        end
    end

endmodule

/* design/text_background_fetch_address_gen_core.sv */
// ---------------------------------------------------------------------------
// text_background_fetch_address_gen_core
// Address generator for one scrolling tiled text background layer.
// ---------------------------------------------------------------------------
// Input stream (s_): tuser = 0 starts a scanline (line number in tdata),
// tuser = 1 hands back a fetched 16-bit map entry. Output stream (m_):
// tuser = 0 is a map word fetch request, tuser = 1 a pixel byte address;
// tlast marks the final transaction produced by one input transaction.
// Configuration is written through cfg_wr_en / cfg_index / cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
// Start of line: the sequencer commits the wrapped map row, then loads the
// fetch request into the output register; with mosaic on, a bit-serial
// remainder loop for the floor runs first. Map entry: one pixel per cycle
// while the output is free, up to the tile edge (at most 8), then the next
// fetch request. Items are processed one at a time by the sequencer.
// Reset (synchronous, aresetn low) clears the line state, output valid and
// all config registers (mosaic height to 1). A stalled receiver holds the
// output register; the sequencer waits until it drains before loading more.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module text_background_fetch_address_gen_core #(
    parameter int SCREEN_COLUMNS     = 240,
    parameter int SCREEN_BLOCK_BYTES = 2048
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tbfag_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tbfag_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // scanline[7:0], map_entry[23:8]
    input  logic                              s_tuser,   // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata,   // address[31:0], odd_pixel[32],
                                                         // palette[36:33], screen_x[44:37]
    output logic                              m_tuser,   // kind
    output logic                              m_tlast    // last
);
    import tbfag_pkg::*;

    cmd_t        cmd;
    status_t     status;
    logic [31:0] out_addr;
    logic        out_odd;
    logic [3:0]  out_pal;
    logic [7:0]  out_x;

    tbfag_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_action (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    tbfag_datapath #(
        .SCREEN_COLUMNS     (SCREEN_COLUMNS),
        .SCREEN_BLOCK_BYTES (SCREEN_BLOCK_BYTES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_scanline (s_tdata[7:0]),
        .in_entry    (s_tdata[23:8]),
        .cmd         (cmd),
        .status      (status),
        .out_kind    (m_tuser),
        .out_addr    (out_addr),
        .out_odd     (out_odd),
        .out_pal     (out_pal),
        .out_x       (out_x),
        .out_last    (m_tlast)
    );

    assign m_tdata = {3'b000, out_x, out_pal, out_odd, out_addr};

    // output register is only reloaded once its transaction has gone out
    `ASSERT_ALWAYS(a_load_when_free, aclk, aresetn, !(cmd.out_fetch || cmd.out_pix) || !m_tvalid || m_tready);
    `ASSERT_ALWAYS(a_one_load, aclk, aresetn, !(cmd.out_fetch && cmd.out_pix));
    `ASSERT_NEXT(a_load_shows, aclk, aresetn, cmd.out_fetch || cmd.out_pix, m_tvalid);
    // after a start of line is accepted, the sequencer is busy in the following cycle
    `ASSERT_NEXT(a_start_busy, aclk, aresetn, s_tvalid && s_tready && (s_tuser == ACT_START_LINE), !s_tready);

endmodule
